// ----- hw/rtl/ptt_pkg.sv -----
// Package: shared constants, payload structs and control types of the periodic task timer table.
package ptt_pkg;

  // Table geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY     = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCHEDULER_ON = 1'd1;
  localparam logic [4:0]            CAPACITY_RESET   = 5'd16;

  // Input modes
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_RUN_ALL = 3'd1;
  localparam logic [2:0] MODE_ADD     = 3'd2;
  localparam logic [2:0] MODE_ENABLE  = 3'd3;
  localparam logic [2:0] MODE_DISABLE = 3'd4;
  localparam logic [2:0] MODE_SET_IVL = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_FIRED      = 2'd0;
  localparam logic [1:0] KIND_ADD_OK     = 2'd1;
  localparam logic [1:0] KIND_ADD_REJECT = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now;
    logic [3:0]  slot;
    logic [15:0] interval;
    logic        start_enable;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] fired_slot;
    logic       last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // capture transaction, apply table updates
    logic step;     // examine one entry of the walk
    logic flush;    // emit the held fire as final result
    logic resp;     // emit the add response
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_walk;
    logic start_resp;
    logic walk_done;
    logic stall_walk;
    logic pend_valid;
    logic out_free;
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_RESP
  } state_t;

endpackage

// ----- hw/rtl/ptt_ctrl.sv -----
// Controller: sequences acceptance, the table walk, the final flush and add responses.
module ptt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ptt_pkg::status_t status,
  output ptt_pkg::cmd_t    cmd
);
  import ptt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Choose next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.start_walk) begin
            state_nxt = ST_WALK;
          end else if (status.start_resp) begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_WALK: begin
        if (status.walk_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_WALK: begin
        cmd.step = !status.walk_done && !status.stall_walk;
      end
      ST_FLUSH: begin
        cmd.flush = status.pend_valid && status.out_free;
      end
      ST_RESP: begin
        cmd.resp = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- hw/rtl/ptt_datapath.sv -----
// Datapath: timer table, configuration registers, walk index, held fire and output register.
module ptt_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ptt_pkg::in_t                      in_data,
  input  logic                              cfg_we,
  input  logic [ptt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ptt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  ptt_pkg::cmd_t                     cmd,
  output ptt_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ptt_pkg::out_t                     out_data
);
  import ptt_pkg::*;

  // Timer table
  logic [31:0] due_r [ENTRIES];
  logic [15:0] per_r [ENTRIES];
  logic        en_r  [ENTRIES];

  logic [CNT_W-1:0] entry_count_r;
  logic [4:0]       capacity_r;
  logic             sched_on_r;

  // Walk and result state
  logic [CNT_W-1:0] idx_r;
  logic [31:0]      now_r;
  logic             timed_r;
  logic             pend_valid_r;
  logic [IDX_W-1:0] pend_slot_r;
  logic [1:0]       resp_kind_r;
  logic [3:0]       resp_slot_r;
  logic             out_valid_r;
  out_t             out_r;

  logic [CNT_W-1:0] eff_cap;
  logic             add_ok;
  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx;
  logic [IDX_W-1:0] cnt_idx;
  logic [IDX_W-1:0] walk_idx;
  logic             hit;
  logic             out_free;
  logic             push_mid;

  // Decode the offered transaction
  assign eff_cap  = (capacity_r > 5'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(capacity_r);
  assign add_ok   = (entry_count_r < eff_cap) && (entry_count_r < CNT_W'(ENTRIES));
  assign slot_ok  = (CNT_W'(in_data.slot) < entry_count_r);
  assign slot_idx = in_data.slot[IDX_W-1:0];
  assign cnt_idx  = entry_count_r[IDX_W-1:0];

  // Examine the walked entry
  assign walk_idx = idx_r[IDX_W-1:0];
  assign hit      = en_r[walk_idx] && (!timed_r || (due_r[walk_idx] <= now_r));
  assign out_free = !out_valid_r || !out_stall;
  assign push_mid = cmd.step && hit && pend_valid_r;

  always_comb begin
    status            = '0;
    status.start_walk = ((in_data.mode == MODE_TICK) && (entry_count_r != '0) && sched_on_r)
                        || (in_data.mode == MODE_RUN_ALL);
    status.start_resp = (in_data.mode == MODE_ADD);
    status.walk_done  = (idx_r >= entry_count_r);
    status.stall_walk = hit && pend_valid_r && !out_free;
    status.pend_valid = pend_valid_r;
    status.out_free   = out_free;
  end

  // Update table entries
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      case (in_data.mode)
        MODE_ADD: begin
          if (add_ok) begin
            due_r[cnt_idx] <= '0;
            per_r[cnt_idx] <= in_data.interval;
            en_r[cnt_idx]  <= in_data.start_enable;
          end
        end
        MODE_ENABLE, MODE_DISABLE: begin
          if (slot_ok) begin
            en_r[slot_idx] <= (in_data.mode == MODE_ENABLE);
          end
        end
        MODE_SET_IVL: begin
          if (slot_ok) begin
            per_r[slot_idx] <= in_data.interval;
            due_r[slot_idx] <= due_r[slot_idx] + {16'd0, in_data.interval};
          end
        end
        default: ;
      endcase
    end else if (cmd.step && hit) begin
      due_r[walk_idx] <= due_r[walk_idx] + {16'd0, per_r[walk_idx]};
    end
  end

  // Capture the transaction and the add response
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r       <= in_data.now;
      timed_r     <= (in_data.mode == MODE_TICK);
      resp_kind_r <= add_ok ? KIND_ADD_OK : KIND_ADD_REJECT;
      resp_slot_r <= add_ok ? 4'(cnt_idx) : 4'd0;
    end
  end

  // Configuration, count, walk index and held fire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      capacity_r    <= CAPACITY_RESET;
      sched_on_r    <= 1'b1;
      idx_r         <= '0;
      pend_valid_r  <= 1'b0;
      pend_slot_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CAPACITY:     capacity_r <= cfg_wdata[4:0];
          CFG_SCHEDULER_ON: sched_on_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        idx_r        <= '0;
        pend_valid_r <= 1'b0;
        if ((in_data.mode == MODE_ADD) && add_ok) begin
          entry_count_r <= entry_count_r + CNT_W'(1);
        end
      end else if (cmd.step) begin
        idx_r <= idx_r + CNT_W'(1);
        if (hit) begin
          pend_valid_r <= 1'b1;
          pend_slot_r  <= walk_idx;
        end
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_mid || cmd.flush || cmd.resp) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || cmd.flush) begin
      out_r.kind       <= KIND_FIRED;
      out_r.fired_slot <= 4'(pend_slot_r);
      out_r.last       <= cmd.flush;
    end else if (cmd.resp) begin
      out_r.kind       <= resp_kind_r;
      out_r.fired_slot <= resp_slot_r;
      out_r.last       <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hw/rtl/periodic_task_timer_table.sv -----
// A tick or run-all walks the table one entry per cycle unless the result side stalls, one table
// read per step, then flushes its last result; an add gives a single response.
// Flow: one transaction at a time; a set, enable, disable or silent tick leaves the block idle,
// while an add or a walk stalls the input until its last result, if any, is loaded for output.
// Reset (synchronous, rst_n low): table empty, capacity 16, scheduler on, no result pending;
// the table entries themselves are not cleared.
module periodic_task_timer_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ptt_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ptt_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [ptt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ptt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ptt_pkg::*;

  cmd_t    cmd;
  status_t status;

  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ptt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/ptt_checker.sv -----
// Checker: port-level assertions on the periodic task timer table, bound to the top level.
module ptt_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input ptt_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input ptt_pkg::out_t out_data
);
  import ptt_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // An accepted add keeps the input stalled while its response is queued
  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.mode == MODE_ADD) |=> in_stall)
    else $error("add transaction did not occupy the block");

  // Add responses are single results
  a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != KIND_FIRED) |-> out_data.last)
    else $error("add response without last flag");

  // A rejected add names slot zero
  a_reject_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_ADD_REJECT) |-> (out_data.fired_slot == 4'd0))
    else $error("rejected add carries a slot");

  // No result kind outside the defined set
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind == KIND_FIRED) || (out_data.kind == KIND_ADD_OK)
                  || (out_data.kind == KIND_ADD_REJECT))
    else $error("undefined result kind");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/sv/ptt_checker.sv -----
`timescale 1ns / 1ps
// Checker for the timer table: models the table, predicts result transactions and compares them.
module ptt_tb_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  ptt_pkg::in_t                   in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  ptt_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [ptt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ptt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             owed,
  output int                             mismatches
);
  import ptt_pkg::*;

  // Shadow copy of the timer table and its registers
  logic [31:0] due_ms    [ENTRIES];
  logic [15:0] period_ms [ENTRIES];
  bit          armed     [ENTRIES];
  int unsigned used;
  logic [4:0]  capacity;
  bit          sched_on;

  // Results still owed by the block, oldest first
  out_t owed_results[$];

  // Apply one accepted transaction to the shadow table and queue what it must produce
  task automatic apply_timer_item(in_t it);
    out_t batch[$];
    out_t r;
    int   lim;
    case (it.mode)
      MODE_TICK, MODE_RUN_ALL: begin
        if (it.mode == MODE_RUN_ALL || sched_on) begin
          for (int i = 0; i < used; i++) begin
            if (armed[i] && (it.mode == MODE_RUN_ALL || due_ms[i] <= it.now)) begin
              r.kind       = KIND_FIRED;
              r.fired_slot = 4'(i);
              r.last       = 1'b0;
              batch.push_back(r);
              due_ms[i] = due_ms[i] + 32'(period_ms[i]);
            end
          end
        end
      end
      MODE_ADD: begin
        lim = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
        if (used >= lim) begin
          r.kind       = KIND_ADD_REJECT;
          r.fired_slot = '0;
        end else begin
          due_ms[used]    = '0;
          period_ms[used] = it.interval;
          armed[used]     = it.start_enable;
          r.kind          = KIND_ADD_OK;
          r.fired_slot    = 4'(used);
          used++;
        end
        r.last = 1'b0;
        batch.push_back(r);
      end
      MODE_ENABLE, MODE_DISABLE: begin
        if (it.slot < used) armed[it.slot] = (it.mode == MODE_ENABLE);
      end
      MODE_SET_IVL: begin
        if (it.slot < used) begin
          period_ms[it.slot] = it.interval;
          due_ms[it.slot]    = due_ms[it.slot] + 32'(it.interval);
        end
      end
      default: ;
    endcase
    // Mark the final result of this transaction
    foreach (batch[k]) begin
      r      = batch[k];
      r.last = (k == batch.size() - 1);
      owed_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      used       = 0;
      capacity   = CAPACITY_RESET;
      sched_on   = 1'b1;
      mismatches = 0;
      owed_results.delete();
    end else begin
      // Register writes are only to land while the block is idle, a rule on the user that the block does not enforce
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CAPACITY:     capacity = cfg_wdata;
          CFG_SCHEDULER_ON: sched_on = cfg_wdata[0];
          default: ;
        endcase
      end
      // Compare a result transaction with the oldest prediction
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d slot %0d last %0b",
                     out_data.kind, out_data.fired_slot, out_data.last);
        end else begin
          if (out_data.kind !== owed_results[0].kind ||
              out_data.fired_slot !== owed_results[0].fired_slot ||
              out_data.last !== owed_results[0].last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected kind %0d slot %0d last %0b, ",
                        "got kind %0d slot %0d last %0b"},
                       owed_results[0].kind, owed_results[0].fired_slot, owed_results[0].last,
                       out_data.kind, out_data.fired_slot, out_data.last);
          end
          void'(owed_results.pop_front());
        end
      end
      // Predict after comparing: a transaction's results never leave on its own accept edge
      if (in_valid && !in_stall) apply_timer_item(in_data);
    end
    owed = owed_results.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives the timer table through its configuration phases and reports the verdict.
module tb;
  import ptt_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int          owed;
  int          mismatches;
  int          idle_pct      = 0;
  int          stall_pct     = 0;
  int          hold_requests = 0;
  int          holds_served  = 0;
  int          hold_left     = 0;
  logic [31:0] clock_ms      = '0;

  always #4 clk = ~clk;

  periodic_task_timer_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  ptt_tb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .owed       (owed),
    .mismatches (mismatches)
  );

  // Result side: random stall, or a long hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Give up on a hung run
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic in_t timer_item(logic [2:0] mode, logic [31:0] now, logic [3:0] slot,
                                     logic [15:0] interval, logic start_enable);
    in_t it;
    it.mode         = mode;
    it.now          = now;
    it.slot         = slot;
    it.interval     = interval;
    it.start_enable = start_enable;
    return it;
  endfunction

  // Periods: mostly short so that ticks fire often, now and then zero or anything
  function automatic logic [15:0] pick_period();
    int p;
    p = $urandom_range(7);
    if (p == 0) return '0;
    if (p == 1) return 16'($urandom());
    return 16'($urandom_range(60, 1));
  endfunction

  function automatic in_t random_timer_item();
    in_t it;
    int  pick;
    it.now          = $urandom();
    it.slot         = 4'($urandom());
    it.interval     = 16'($urandom());
    it.start_enable = 1'($urandom());
    pick = $urandom_range(99);
    if (pick < 45) begin
      it.mode = MODE_TICK;
      // Advance the running clock in small steps, sometimes jump anywhere
      if ($urandom_range(9) != 0) begin
        clock_ms = clock_ms + 32'($urandom_range(40));
        it.now   = clock_ms;
      end
    end else if (pick < 53) begin
      it.mode = MODE_RUN_ALL;
    end else if (pick < 67) begin
      it.mode     = MODE_ADD;
      it.interval = pick_period();
    end else if (pick < 77) begin
      it.mode = MODE_ENABLE;
    end else if (pick < 85) begin
      it.mode = MODE_DISABLE;
    end else if (pick < 95) begin
      it.mode     = MODE_SET_IVL;
      it.interval = pick_period();
    end else begin
      it.mode = 3'($urandom_range(7, 6));
    end
    return it;
  endfunction

  // Offer one transaction; entered and left at a falling edge
  task automatic send_item(in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drain: drop valid, wait for every owed result, then cover a walk that yields nothing
  task automatic settle();
    in_valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int caps   [4];
    int idles  [4];
    int stalls [4];
    caps   = '{5, 9, 31, 16};
    idles  = '{0, 69, 0, 26};
    stalls = '{0, 0, 69, 26};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table, unused slots, then three entries with extreme periods
    send_item(timer_item(MODE_TICK, 32'h0, 4'h0, 16'h0, 1'b0));
    send_item(timer_item(MODE_RUN_ALL, 32'h0, 4'h0, 16'h0, 1'b0));
    send_item(timer_item(MODE_ENABLE, 32'h0, 4'h0, 16'h0, 1'b0));
    send_item(timer_item(MODE_SET_IVL, 32'h0, 4'h0, 16'h5, 1'b0));
    send_item(timer_item(MODE_ADD, 32'h0, 4'h0, 16'h0, 1'b1));
    send_item(timer_item(MODE_ADD, 32'h0, 4'h0, 16'hFFFF, 1'b0));
    send_item(timer_item(MODE_ADD, 32'h0, 4'h0, 16'h1, 1'b1));
    send_item(timer_item(MODE_TICK, 32'h0, 4'h0, 16'h0, 1'b0));
    send_item(timer_item(MODE_TICK, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 1'b1));
    send_item(timer_item(MODE_ENABLE, 32'h0, 4'h1, 16'h0, 1'b0));
    send_item(timer_item(MODE_DISABLE, 32'h0, 4'h0, 16'h0, 1'b0));
    send_item(timer_item(MODE_SET_IVL, 32'h0, 4'h2, 16'hFFFF, 1'b0));
    send_item(timer_item(MODE_SET_IVL, 32'h0, 4'hF, 16'hFFFF, 1'b1));
    send_item(timer_item(MODE_DISABLE, 32'h0, 4'h3, 16'h0, 1'b0));
    send_item(timer_item(MODE_RUN_ALL, 32'h0, 4'h0, 16'h0, 1'b0));
    send_item(timer_item(3'd6, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 1'b1));
    send_item(timer_item(3'd7, 32'h0, 4'h0, 16'h0, 1'b0));
    send_item(timer_item(MODE_TICK, 32'h0, 4'h0, 16'h0, 1'b0));
    send_item(timer_item(MODE_ADD, 32'h0, 4'h0, 16'hAAAA, 1'b1));
    send_item(timer_item(MODE_TICK, 32'h8000_0000, 4'h0, 16'h0, 1'b0));

    // Capacity below the entries in use, then zero: adds are refused
    settle();
    write_cfg(CFG_CAPACITY, 5'd2);
    send_item(timer_item(MODE_ADD, 32'h0, 4'h0, 16'h7, 1'b1));
    settle();
    write_cfg(CFG_CAPACITY, 5'd0);
    send_item(timer_item(MODE_ADD, 32'h0, 4'h0, 16'h7, 1'b1));

    // Scheduler off: ticks stay silent, run-all still fires
    settle();
    write_cfg(CFG_SCHEDULER_ON, 5'd0);
    send_item(timer_item(MODE_TICK, 32'hFFFF_FFFF, 4'h0, 16'h0, 1'b0));
    send_item(timer_item(MODE_RUN_ALL, 32'h0, 4'h0, 16'h0, 1'b0));
    settle();
    write_cfg(CFG_SCHEDULER_ON, 5'd1);

    // Random phases, each under its own idling mix and capacity
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      idle_pct  = idles[ph];
      stall_pct = stalls[ph];
      write_cfg(CFG_CAPACITY, 5'(caps[ph]));
      if (ph == 1) begin
        write_cfg(CFG_SCHEDULER_ON, 5'd0);
        repeat (10) send_item(random_timer_item());
        settle();
        write_cfg(CFG_SCHEDULER_ON, 5'd1);
      end
      for (int n = 0; n < 65; n++) begin
        // Hold the result side off while items keep coming, so the block backs up
        if (ph == 0 && n == 20) hold_requests++;
        send_item(random_timer_item());
      end
    end

    settle();
    if (mismatches == 0 && owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- periodic_task_timer_table.f -----
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ctrl.sv
hw/rtl/ptt_datapath.sv
hw/rtl/periodic_task_timer_table.sv
hw/rtl/ptt_checker.sv
tb/sv/ptt_checker.sv
tb/sv/tb.sv
